### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/imaprlc_pkg.sv
package imaprlc_pkg;

   localparam int MAX_LINE_BYTES = 4096;
   localparam int POS_W          = 13;
   localparam logic [POS_W-1:0] LINE_MAX = POS_W'(MAX_LINE_BYTES);

   typedef enum logic [3:0] {
      PH_START,
      PH_CONT_SEP,
      PH_CONT_SKIP,
      PH_UNT_SEP,
      PH_UNT_ATOM,
      PH_UNT_SKIP,
      PH_TAG_ATOM,
      PH_TAG_SKIP,
      PH_STAT_ATOM,
      PH_STAT_SKIP,
      PH_TEXT
   } phase_type;

   // line kinds
   localparam logic [1:0] KIND_CONT     = 2'd0;
   localparam logic [1:0] KIND_UNTAGGED = 2'd1;
   localparam logic [1:0] KIND_TAGGED   = 2'd2;

   // status codes
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_NO      = 3'd2;
   localparam logic [2:0] ST_BAD     = 3'd3;
   localparam logic [2:0] ST_PREAUTH = 3'd4;
   localparam logic [2:0] ST_BYE     = 3'd5;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_BYTE   = 3'd1;
   localparam logic [2:0] ERR_CONT       = 3'd2;
   localparam logic [2:0] ERR_UNTAGGED   = 3'd3;
   localparam logic [2:0] ERR_UNT_ATOM   = 3'd4;
   localparam logic [2:0] ERR_TAGGED     = 3'd5;
   localparam logic [2:0] ERR_TAG_STATUS = 3'd6;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd7;

   typedef struct packed {
      phase_type        phase;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] tag_bytes;
      logic [POS_W-1:0] text_offset;
      logic [55:0]      letters;
      logic [3:0]       count;
      logic [1:0]       kind;
      logic [2:0]       fault;
   } line_state_type;

   typedef struct packed {
      logic             valid_res;
      logic [1:0]       kind;
      logic [2:0]       status;
      logic [POS_W-1:0] tag_length;
      logic [POS_W-1:0] text_start;
      logic [POS_W-1:0] line_length;
      logic [2:0]       error_code;
   } result_type;

   localparam line_state_type LINE_CLEAR = '{
      phase:       PH_START,
      pos:         '0,
      tag_bytes:   '0,
      text_offset: '0,
      letters:     '0,
      count:       '0,
      kind:        KIND_CONT,
      fault:       ERR_NONE
   };

endpackage

### hw/rtl/imaprlc_step.sv
module imaprlc_step
   import imaprlc_pkg::*;
(
   input  logic [7:0]     item_byte,
   input  logic           item_end,
   input  line_state_type line_cur,
   output line_state_type line_nxt,
   output result_type     result
);

   // status atoms, first letter in the low byte
   localparam logic [55:0] TXT_OK      = 56'h00000000004B4F;
   localparam logic [55:0] TXT_NO      = 56'h00000000004F4E;
   localparam logic [55:0] TXT_BAD     = 56'h00000000444142;
   localparam logic [55:0] TXT_PREAUTH = 56'h48545541455250;
   localparam logic [55:0] TXT_BYE     = 56'h00000000455942;

   line_state_type upd;
   line_state_type fin;
   logic [55:0]    push_letters;
   logic [3:0]     push_count;
   logic [7:0]     upper;
   logic           is_space;
   logic           is_atom;
   logic           is_ctrl;
   logic           set_hit;
   logic [2:0]     set_code;
   logic [2:0]     st;

   assign is_space = (item_byte == 8'h20);
   assign is_ctrl  = (item_byte < 8'd32) && (item_byte != 8'h09);
   assign is_atom  = (item_byte > 8'd31) && (item_byte != 8'h7F) &&
                     (item_byte != 8'h28) && (item_byte != 8'h29) &&
                     (item_byte != 8'h7B) && (item_byte != 8'h20) &&
                     (item_byte != 8'h25) && (item_byte != 8'h2A) &&
                     (item_byte != 8'h22) && (item_byte != 8'h5C) &&
                     (item_byte != 8'h5D);
   assign upper    = ((item_byte >= 8'h61) && (item_byte <= 8'h7A)) ?
                     (item_byte - 8'd32) : item_byte;

   // atom letter buffer: keeps 7 letters, count stops at 8
   always_comb begin
      push_letters = line_cur.letters;
      for (int i = 0; i < 7; i++) begin
         if (line_cur.count == 4'(i)) begin
            push_letters[i*8 +: 8] = upper;
         end
      end
      push_count = (line_cur.count < 4'd8) ? (line_cur.count + 4'd1) : line_cur.count;
   end

   // next state after one byte
   always_comb begin
      upd      = line_cur;
      set_hit  = 1'b0;
      set_code = ERR_NONE;
      if (line_cur.fault != ERR_TOO_LONG) begin
         if (line_cur.pos >= LINE_MAX) begin
            upd.fault = ERR_TOO_LONG;
            upd.phase = PH_TEXT;
         end else begin
            upd.pos = line_cur.pos + 1'b1;
            case (line_cur.phase)
               PH_START: begin
                  if (item_byte == 8'h2B) begin
                     upd.kind  = KIND_CONT;
                     upd.phase = PH_CONT_SEP;
                  end else if (item_byte == 8'h2A) begin
                     upd.kind  = KIND_UNTAGGED;
                     upd.phase = PH_UNT_SEP;
                  end else begin
                     upd.kind = KIND_TAGGED;
                     if (is_atom) begin
                        upd.tag_bytes = POS_W'(1);
                        upd.phase     = PH_TAG_ATOM;
                     end else begin
                        set_hit  = 1'b1;
                        set_code = ERR_TAGGED;
                     end
                  end
               end
               PH_CONT_SEP: begin
                  if (is_space) begin
                     upd.phase = PH_CONT_SKIP;
                  end else begin
                     set_hit  = 1'b1;
                     set_code = ERR_CONT;
                  end
               end
               PH_UNT_SEP: begin
                  if (is_space) begin
                     upd.phase = PH_UNT_ATOM;
                  end else begin
                     set_hit  = 1'b1;
                     set_code = ERR_UNTAGGED;
                  end
               end
               PH_CONT_SKIP, PH_UNT_SKIP, PH_STAT_SKIP: begin
                  if (!is_space) begin
                     upd.text_offset = line_cur.pos;
                     upd.phase       = PH_TEXT;
                  end
               end
               PH_UNT_ATOM: begin
                  if (is_space) begin
                     if (line_cur.count == 4'd0) begin
                        set_hit  = 1'b1;
                        set_code = ERR_UNT_ATOM;
                     end else begin
                        upd.phase = PH_UNT_SKIP;
                     end
                  end else if (is_atom) begin
                     upd.letters = push_letters;
                     upd.count   = push_count;
                  end else begin
                     set_hit  = 1'b1;
                     set_code = ERR_UNT_ATOM;
                  end
               end
               PH_TAG_ATOM: begin
                  if (is_space) begin
                     upd.phase = PH_TAG_SKIP;
                  end else if (is_atom) begin
                     if (line_cur.tag_bytes != '1) begin
                        upd.tag_bytes = line_cur.tag_bytes + 1'b1;
                     end
                  end else begin
                     set_hit  = 1'b1;
                     set_code = ERR_TAGGED;
                  end
               end
               PH_TAG_SKIP: begin
                  if (!is_space) begin
                     if (is_atom) begin
                        upd.letters = push_letters;
                        upd.count   = push_count;
                        upd.phase   = PH_STAT_ATOM;
                     end else begin
                        set_hit  = 1'b1;
                        set_code = ERR_TAG_STATUS;
                     end
                  end
               end
               PH_STAT_ATOM: begin
                  if (is_space) begin
                     upd.phase = PH_STAT_SKIP;
                  end else if (is_atom) begin
                     upd.letters = push_letters;
                     upd.count   = push_count;
                  end else begin
                     set_hit  = 1'b1;
                     set_code = ERR_TAG_STATUS;
                  end
               end
               default: begin
               end
            endcase
            // first structural error sticks, any error parks the parser
            if (set_hit) begin
               if (line_cur.fault == ERR_NONE) begin
                  upd.fault = set_code;
               end
               upd.phase = PH_TEXT;
            end
            if (is_ctrl) begin
               upd.fault = ERR_BAD_BYTE;
            end
         end
      end
   end

   // end of line checks and result fields
   always_comb begin
      fin = upd;
      if (upd.fault == ERR_NONE) begin
         case (upd.phase)
            PH_UNT_SEP:   fin.fault = ERR_UNTAGGED;
            PH_UNT_ATOM: begin
               if (upd.count == 4'd0) begin
                  fin.fault = ERR_UNTAGGED;
               end else begin
                  fin.text_offset = upd.pos;
               end
            end
            PH_TAG_ATOM:  fin.fault = ERR_TAGGED;
            PH_TAG_SKIP:  fin.fault = ERR_TAG_STATUS;
            PH_TEXT: begin
            end
            default:      fin.text_offset = upd.pos;
         endcase
      end

      if      ((upd.count == 4'd2) && (upd.letters == TXT_OK))      st = ST_OK;
      else if ((upd.count == 4'd2) && (upd.letters == TXT_NO))      st = ST_NO;
      else if ((upd.count == 4'd3) && (upd.letters == TXT_BAD))     st = ST_BAD;
      else if ((upd.count == 4'd7) && (upd.letters == TXT_PREAUTH)) st = ST_PREAUTH;
      else if ((upd.count == 4'd3) && (upd.letters == TXT_BYE))     st = ST_BYE;
      else                                                          st = ST_NONE;

      result             = '0;
      result.line_length = upd.pos;
      if (fin.fault == ERR_NONE) begin
         result.kind       = upd.kind;
         result.text_start = fin.text_offset;
         if (upd.kind != KIND_CONT) begin
            result.status = st;
         end
         if ((upd.kind == KIND_UNTAGGED) && (st == ST_NONE)) begin
            result.text_start = POS_W'(2);
         end
         if (upd.kind == KIND_TAGGED) begin
            result.tag_length = upd.tag_bytes;
            if ((st != ST_OK) && (st != ST_NO) && (st != ST_BAD)) begin
               fin.fault = ERR_TAG_STATUS;
            end
         end
      end
      if (fin.fault != ERR_NONE) begin
         result.kind       = KIND_CONT;
         result.status     = ST_NONE;
         result.tag_length = '0;
         result.text_start = '0;
      end
      result.valid_res  = (fin.fault == ERR_NONE);
      result.error_code = fin.fault;

      line_nxt = item_end ? LINE_CLEAR : upd;
   end

endmodule

### hw/rtl/imap_response_line_classifier.sv
// A line's result reaches the rsp_ ports through the input register and then
// the result register after its last byte is accepted.
// Throughput: one byte per cycle, sustained while results are taken; the parse
// step is a single combinational pass between the input register and the
// result register. A stalled result holds the whole pipe, new bytes included.
// Reset (synchronous, active high) empties both registers and returns the
// line state to the start of a line; no result is pending after reset.
module imap_response_line_classifier
   import imaprlc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_line_byte,
   input  logic             req_line_end,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_valid_res,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_status,
   output logic [POS_W-1:0] rsp_tag_length,
   output logic [POS_W-1:0] rsp_text_start,
   output logic [POS_W-1:0] rsp_line_length,
   output logic [2:0]       rsp_error_code
);

   // Pipeline: input register -> parse step -> result register.
   // The whole pipe moves whenever the result register is free or being
   // taken, so a waiting result holds the whole pipe, new bytes included, and never drops one.
   logic           advance;

   // input register
   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_end_ff;

   // line state carried from byte to byte
   line_state_type line_ff;
   line_state_type line_in;
   line_state_type line_step;

   // result register
   logic           out_valid_ff;
   logic           out_valid_in;
   result_type     out_ff;
   result_type     out_step;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign in_valid_in  = advance ? req_valid : in_valid_ff;
   // only the last byte of a line yields an item
   assign out_valid_in = advance ? (in_valid_ff && in_end_ff) : out_valid_ff;
   // line state moves only when a byte really passes through the step
   assign line_in      = (advance && in_valid_ff) ? line_step : line_ff;

   imaprlc_step u_step (
      .item_byte (in_byte_ff),
      .item_end  (in_end_ff),
      .line_cur  (line_ff),
      .line_nxt  (line_step),
      .result    (out_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_ff      <= LINE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         line_ff      <= line_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_line_byte;
         in_end_ff  <= req_line_end;
         out_ff     <= out_step;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_valid_res   = out_ff.valid_res;
   assign rsp_kind        = out_ff.kind;
   assign rsp_status      = out_ff.status;
   assign rsp_tag_length  = out_ff.tag_length;
   assign rsp_text_start  = out_ff.text_start;
   assign rsp_line_length = out_ff.line_length;
   assign rsp_error_code  = out_ff.error_code;

endmodule

### hw/rtl/imaprlc_checker.sv
`include "assert_macros.svh"

module imaprlc_checker
   import imaprlc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [7:0]       req_line_byte,
   input logic             req_line_end,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_valid_res,
   input logic [1:0]       rsp_kind,
   input logic [2:0]       rsp_status,
   input logic [POS_W-1:0] rsp_tag_length,
   input logic [POS_W-1:0] rsp_text_start,
   input logic [POS_W-1:0] rsp_line_length,
   input logic [2:0]       rsp_error_code
);

   logic unused_in;
   assign unused_in = req_valid ^ req_stall ^ (^req_line_byte) ^ req_line_end;

   `ASSERT_IMPLY(a_valid_vs_error, clock, reset, rsp_valid,
      rsp_valid_res == (rsp_error_code == ERR_NONE), "valid_res disagrees with error code")

   `ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res,
      (rsp_kind == KIND_CONT) && (rsp_status == ST_NONE) && (rsp_tag_length == '0) &&
      (rsp_text_start == '0), "invalid line carries nonzero fields")

   `ASSERT_IMPLY(a_tagged_status, clock, reset,
      rsp_valid && rsp_valid_res && (rsp_kind == KIND_TAGGED),
      ((rsp_status == ST_OK) || (rsp_status == ST_NO) || (rsp_status == ST_BAD)) &&
      (rsp_tag_length != '0) && (rsp_text_start <= rsp_line_length),
      "tagged line with bad status, tag or text offset")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_error_code) && $stable(rsp_line_length) &&
      $stable(rsp_text_start), "stalled item changed")

endmodule

bind imap_response_line_classifier imaprlc_checker u_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench
   import imaprlc_pkg::*;
();

   // Overall run limit in clock cycles. A correct run is about 1400 bytes,
   // with random sender gaps between bursts and receiver back-pressure on
   // up to one line result per byte, well under a tenth of this.
   localparam int CYCLE_LIMIT = 400_000;
   // Number of random bytes to send after the directed lines.
   localparam int RANDOM_BYTES = 1370;
   // The result passes the input and result registers after the last byte; wait longer.
   localparam int DRAIN_CYCLES = 20;

   // -----------------------------------------------------------------------
   // Line parser model plus the queue of line results still to arrive.
   // note_byte() follows each accepted byte; check_line() takes each
   // accepted result and compares it with the oldest predicted one.
   // -----------------------------------------------------------------------
   class line_scoreboard;
      line_state_type st;
      result_type     pending_lines[$];
      int             errors;

      function new();
         st     = LINE_CLEAR;
         errors = 0;
      endfunction

      function bit is_atom_byte(logic [7:0] b);
         if (b <= 8'd31 || b == 8'h7F)
            return 1'b0;
         case (b)
            "(", ")", "{", " ", "%", "*", "\"", "\\", "]": return 1'b0;
            default: return 1'b1;
         endcase
      endfunction

      // uppercase and keep up to 7 letters; the count saturates at 8
      function void push_atom(logic [7:0] b);
         if (b >= "a" && b <= "z")
            b = b - 8'd32;
         if (st.count < 7)
            st.letters[8*st.count +: 8] = b;
         if (st.count < 8)
            st.count++;
      endfunction

      // first structural fault wins; the line is then just skipped
      function void raise_fault(logic [2:0] code);
         if (st.fault == ERR_NONE)
            st.fault = code;
         st.phase = PH_TEXT;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [POS_W-1:0] at;
         logic [POS_W-1:0] len;
         logic [POS_W-1:0] start;
         logic [POS_W-1:0] tags;
         logic [2:0]       status;
         logic [1:0]       kind;
         logic [55:0]      word;
         result_type       r;
         if (st.fault != ERR_TOO_LONG) begin
            if (st.pos >= LINE_MAX) begin
               st.fault = ERR_TOO_LONG;
               st.phase = PH_TEXT;
            end else begin
               at = st.pos;
               st.pos++;
               case (st.phase)
                  PH_START: begin
                     if (b == "+") begin
                        st.kind  = KIND_CONT;
                        st.phase = PH_CONT_SEP;
                     end else if (b == "*") begin
                        st.kind  = KIND_UNTAGGED;
                        st.phase = PH_UNT_SEP;
                     end else begin
                        st.kind = KIND_TAGGED;
                        if (is_atom_byte(b)) begin
                           st.tag_bytes = POS_W'(1);
                           st.phase     = PH_TAG_ATOM;
                        end else begin
                           raise_fault(ERR_TAGGED);
                        end
                     end
                  end
                  PH_CONT_SEP: begin
                     if (b == " ") st.phase = PH_CONT_SKIP;
                     else raise_fault(ERR_CONT);
                  end
                  PH_UNT_SEP: begin
                     if (b == " ") st.phase = PH_UNT_ATOM;
                     else raise_fault(ERR_UNTAGGED);
                  end
                  PH_CONT_SKIP, PH_UNT_SKIP, PH_STAT_SKIP: begin
                     if (b != " ") begin
                        st.text_offset = at;
                        st.phase       = PH_TEXT;
                     end
                  end
                  PH_UNT_ATOM: begin
                     if (b == " ") begin
                        if (st.count == 0) raise_fault(ERR_UNT_ATOM);
                        else st.phase = PH_UNT_SKIP;
                     end else if (is_atom_byte(b)) begin
                        push_atom(b);
                     end else begin
                        raise_fault(ERR_UNT_ATOM);
                     end
                  end
                  PH_TAG_ATOM: begin
                     if (b == " ") begin
                        st.phase = PH_TAG_SKIP;
                     end else if (is_atom_byte(b)) begin
                        if (st.tag_bytes != '1) st.tag_bytes++;
                     end else begin
                        raise_fault(ERR_TAGGED);
                     end
                  end
                  PH_TAG_SKIP: begin
                     if (b != " ") begin
                        if (is_atom_byte(b)) begin
                           push_atom(b);
                           st.phase = PH_STAT_ATOM;
                        end else begin
                           raise_fault(ERR_TAG_STATUS);
                        end
                     end
                  end
                  PH_STAT_ATOM: begin
                     if (b == " ") st.phase = PH_STAT_SKIP;
                     else if (is_atom_byte(b)) push_atom(b);
                     else raise_fault(ERR_TAG_STATUS);
                  end
                  default: ;
               endcase
               // control bytes override any structural fault
               if (b < 8'd32 && b != "\t")
                  st.fault = ERR_BAD_BYTE;
            end
         end
         if (!last)
            return;

         // end of line: close whatever phase we are in
         len    = st.pos;
         start  = '0;
         tags   = '0;
         kind   = KIND_CONT;
         status = ST_NONE;
         if (st.fault == ERR_NONE) begin
            case (st.phase)
               PH_UNT_SEP: raise_fault(ERR_UNTAGGED);
               PH_UNT_ATOM: begin
                  if (st.count == 0) raise_fault(ERR_UNTAGGED);
                  else st.text_offset = len;
               end
               PH_TAG_ATOM: raise_fault(ERR_TAGGED);
               PH_TAG_SKIP: raise_fault(ERR_TAG_STATUS);
               PH_TEXT: ;
               default: st.text_offset = len;
            endcase
         end
         if (st.fault == ERR_NONE) begin
            kind  = st.kind;
            start = st.text_offset;
            if (kind != KIND_CONT) begin
               // letters are stored first-byte-low; rebuild in reading order
               word = '0;
               for (int i = 0; i < 7; i++)
                  if (i < st.count) word = {word[47:0], st.letters[8*i +: 8]};
               if (st.count == 2 && word[15:0] == "OK") status = ST_OK;
               else if (st.count == 2 && word[15:0] == "NO") status = ST_NO;
               else if (st.count == 3 && word[23:0] == "BAD") status = ST_BAD;
               else if (st.count == 3 && word[23:0] == "BYE") status = ST_BYE;
               else if (st.count == 7 && word == "PREAUTH") status = ST_PREAUTH;
            end
            if (kind == KIND_UNTAGGED && status == ST_NONE)
               start = POS_W'(2);
            if (kind == KIND_TAGGED) begin
               if (status < ST_OK || status > ST_BAD) raise_fault(ERR_TAG_STATUS);
               tags = st.tag_bytes;
            end
         end
         if (st.fault != ERR_NONE) begin
            kind   = KIND_CONT;
            status = ST_NONE;
            tags   = '0;
            start  = '0;
         end
         r.valid_res   = (st.fault == ERR_NONE);
         r.kind        = kind;
         r.status      = status;
         r.tag_length  = tags;
         r.text_start  = start;
         r.line_length = len;
         r.error_code  = st.fault;
         pending_lines.push_back(r);
         st = LINE_CLEAR;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_line(result_type got);
         result_type want;
         if (pending_lines.size() == 0) begin
            $display("%0t: result with no line pending: expected none, actual %p",
                     $time, got);
            errors++;
            return;
         end
         want = pending_lines.pop_front();
         compare_field("valid_res", want.valid_res, got.valid_res);
         compare_field("kind", want.kind, got.kind);
         compare_field("status", want.status, got.status);
         compare_field("tag_length", want.tag_length, got.tag_length);
         compare_field("text_start", want.text_start, got.text_start);
         compare_field("line_length", want.line_length, got.line_length);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Clock, reset and block ports. All inputs start at known values.
   // -----------------------------------------------------------------------
   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic [7:0]       req_line_byte = 8'h00;
   logic             req_line_end  = 1'b0;
   logic             rsp_stall     = 1'b1;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_valid_res;
   logic [1:0]       rsp_kind;
   logic [2:0]       rsp_status;
   logic [POS_W-1:0] rsp_tag_length;
   logic [POS_W-1:0] rsp_text_start;
   logic [POS_W-1:0] rsp_line_length;
   logic [2:0]       rsp_error_code;

   always #10 clock = ~clock;

   imap_response_line_classifier u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_byte   (req_line_byte),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_tag_length  (rsp_tag_length),
      .rsp_text_start  (rsp_text_start),
      .rsp_line_length (rsp_line_length),
      .rsp_error_code  (rsp_error_code)
   );

   line_scoreboard sb = new();

   // -----------------------------------------------------------------------
   // Receiver: stall pattern changes mode after a run of random length -
   // never stall, coin flip, mostly stalled, or a fixed 1-in-4 beat.
   // -----------------------------------------------------------------------
   int stall_mode = 0;
   int stall_run  = 0;

   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(20, 150);
      end
      stall_run--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_run % 4 == 0);
      endcase
   end

   // result monitor: registered outputs, sampled at the edge that accepts them
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.valid_res   = rsp_valid_res;
         got.kind        = rsp_kind;
         got.status      = rsp_status;
         got.tag_length  = rsp_tag_length;
         got.text_start  = rsp_text_start;
         got.line_length = rsp_line_length;
         got.error_code  = rsp_error_code;
         sb.check_line(got);
      end
   end

   // -----------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them. Now and
   // then a long burst gives a stretch of back-to-back bytes.
   // -----------------------------------------------------------------------
   int         burst_left = 0;
   logic [7:0] line_bytes[$];
   string      status_names[5] = '{"OK", "NO", "BAD", "PREAUTH", "BYE"};

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      req_valid     <= 1'b1;
      req_line_byte <= b;
      req_line_end  <= last;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, last);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_line();
      foreach (line_bytes[i])
         send_byte(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         line_bytes.push_back(s[i]);
   endfunction

   task automatic send_text(string s);
      line_bytes.delete();
      push_text(s);
      send_line();
   endtask

   // mostly letters and digits, sometimes any other atom byte (high bytes too)
   function automatic logic [7:0] random_atom_byte();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = 8'($urandom_range("A", "Z"));
         1: b = 8'($urandom_range("a", "z"));
         2: b = 8'($urandom_range("0", "9"));
         default: do b = 8'($urandom_range(33, 255)); while (!sb.is_atom_byte(b));
      endcase
      return b;
   endfunction

   function automatic logic [7:0] random_text_byte();
      case ($urandom_range(0, 19))
         0: return 8'($urandom_range(0, 31));     // control bytes, tab included
         1: return 8'($urandom_range(127, 255));
         2: return "\t";
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic void push_spaces(int lo, int hi);
      repeat ($urandom_range(lo, hi)) line_bytes.push_back(" ");
   endfunction

   // status atom in random letter case; may be a random atom, an overlong
   // status name, or missing altogether
   function automatic void push_status_atom(bit tagged_line);
      int    pick;
      string s;
      pick = tagged_line ? $urandom_range(0, 10) : $urandom_range(0, 7);
      if (pick >= 8) pick = $urandom_range(0, 2);   // bias tagged lines to OK/NO/BAD
      if (pick <= 4 || pick == 6) begin
         s = status_names[pick <= 4 ? pick : $urandom_range(0, 4)];
         for (int i = 0; i < s.len(); i++)
            line_bytes.push_back($urandom_range(0, 1) ? s[i] + 8'd32 : s[i]);
         if (pick == 6)
            repeat ($urandom_range(1, 5)) line_bytes.push_back(random_atom_byte());
      end else if (pick == 5) begin
         repeat ($urandom_range(1, 9)) line_bytes.push_back(random_atom_byte());
      end
   endfunction

   function automatic void push_random_text();
      if ($urandom_range(0, 3) != 0) begin
         push_spaces(0, 3);
         repeat ($urandom_range(0, 20)) line_bytes.push_back(random_text_byte());
      end
   endfunction

   function automatic void make_random_line();
      int cut;
      line_bytes.delete();
      case ($urandom_range(0, 9))
         0, 1: begin
            push_text("+");
            push_random_text();
         end
         2, 3, 4: begin
            push_text("* ");
            push_status_atom(1'b0);
            push_random_text();
         end
         5, 6, 7, 8: begin
            // tag, mostly short, sometimes long
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 6))
               line_bytes.push_back(random_atom_byte());
            push_spaces(1, 3);
            push_status_atom(1'b1);
            push_random_text();
         end
         default: begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      // broken sequences: a corrupted byte or a truncated line
      if ($urandom_range(0, 7) == 0)
         line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, line_bytes.size());
         while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
   endfunction

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      int random_sent;
      random_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_text("+");               // bare continuation
      send_text("+x");              // continuation without a space
      send_text("* bye");           // untagged status, text empty
      send_text("A1 bAd  z");       // tagged, mixed case, two spaces before text
      send_text("t PREAUTH");       // tagged line may not carry PREAUTH
      line_bytes.delete();          // control byte beats the structure check
      push_text("*");
      line_bytes.push_back(8'h00);
      send_line();
      line_bytes.delete();          // top byte value alone: unfinished tag
      line_bytes.push_back(8'hFF);
      send_line();

      // random lines, mostly well formed
      while (random_sent < RANDOM_BYTES) begin
         make_random_line();
         random_sent += line_bytes.size();
         send_line();
      end
      req_valid <= 1'b0;

      while (sb.pending_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hung handshake or missing results end the run here
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

endmodule
